// File: hw/rtl/i2c_master_status_sequencer_core_defines.svh
// ----------------------------------------------------------------------------
// I2C master status sequencer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_STATUS_SEQUENCER_CORE_DEFINES_SVH
`define I2C_MASTER_STATUS_SEQUENCER_CORE_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define I2C_MSS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define I2C_MSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/i2c_mss_pkg.sv
// ----------------------------------------------------------------------------
// I2C master status sequencer package
// Sizes, request and status codes, and the structs shared by the core.
// ----------------------------------------------------------------------------
package i2c_mss_pkg;

  localparam int WRITE_DEPTH = 16;
  localparam int PTR_W = $clog2(WRITE_DEPTH + 1);
  localparam int IDX_W = (WRITE_DEPTH > 1) ? $clog2(WRITE_DEPTH) : 1;

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_EVENT = 2'd2;

  localparam logic [3:0] ST_BUSERR  = 4'd0;
  localparam logic [3:0] ST_START   = 4'd1;
  localparam logic [3:0] ST_RSTART  = 4'd2;
  localparam logic [3:0] ST_AW_ACK  = 4'd3;
  localparam logic [3:0] ST_AW_NACK = 4'd4;
  localparam logic [3:0] ST_TX_ACK  = 4'd5;
  localparam logic [3:0] ST_TX_NACK = 4'd6;
  localparam logic [3:0] ST_ARBLOST = 4'd7;
  localparam logic [3:0] ST_AR_ACK  = 4'd8;
  localparam logic [3:0] ST_AR_NACK = 4'd9;
  localparam logic [3:0] ST_RX_ACK  = 4'd10;
  localparam logic [3:0] ST_RX_NACK = 4'd11;
  localparam logic [3:0] ST_IDLE    = 4'd12;

  localparam logic [2:0] BIT_ACK   = 3'b001;
  localparam logic [2:0] BIT_START = 3'b010;
  localparam logic [2:0] BIT_STOP  = 3'b100;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_BUS       = 2'd1;
  localparam logic [1:0] ERR_NO_DEVICE = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] write_byte;
    logic [6:0] target_address;
    logic [4:0] write_length;
    logic [7:0] read_length;
    logic [3:0] bus_status;
    logic [7:0] received_byte;
  } item_t;

  typedef struct packed {
    logic [7:0]       addr_byte;
    logic [PTR_W-1:0] load_pointer;
    logic [PTR_W-1:0] write_position;
    logic [PTR_W-1:0] write_total;
    logic [7:0]       read_position;
    logic [7:0]       read_total;
    logic             busy;
    logic [1:0]       error;
  } state_t;

  typedef struct packed {
    logic [2:0] set_bits;
    logic [2:0] clear_bits;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic [7:0] rx_index;
    logic       busy_res;
    logic [1:0] error_code;
  } result_t;

endpackage

// File: hw/rtl/i2c_mss_step.sv
// ----------------------------------------------------------------------------
// I2C master status sequencer step logic
// Decides the result of one request and the sequencer state that follows it.
// ----------------------------------------------------------------------------
module i2c_mss_step (
  input  i2c_mss_pkg::state_t  cur_state,
  input  i2c_mss_pkg::item_t   item,
  input  logic [7:0]           buf_data,
  output i2c_mss_pkg::state_t  next_state,
  output i2c_mss_pkg::result_t result,
  output logic                 buf_write
);

  logic [7:0] left;
  logic [7:0] left_rx;
  logic       more_write;

  always_comb begin
    left = (cur_state.read_total > cur_state.read_position) ?
           (cur_state.read_total - cur_state.read_position) : 8'd0;
    more_write = (cur_state.write_position < cur_state.write_total) &&
                 (cur_state.write_position < i2c_mss_pkg::PTR_W'(i2c_mss_pkg::WRITE_DEPTH));
    left_rx = left;

    next_state = cur_state;
    result = '0;
    buf_write = 1'b0;

    unique case (item.kind)
      i2c_mss_pkg::KIND_LOAD: begin
        if (cur_state.load_pointer < i2c_mss_pkg::PTR_W'(i2c_mss_pkg::WRITE_DEPTH)) begin
          buf_write = 1'b1;
          next_state.load_pointer = cur_state.load_pointer + 1'b1;
        end
      end
      i2c_mss_pkg::KIND_START: begin
        next_state.addr_byte = {item.target_address, 1'b0};
        if (32'(item.write_length) > i2c_mss_pkg::WRITE_DEPTH) begin
          next_state.write_total = i2c_mss_pkg::PTR_W'(i2c_mss_pkg::WRITE_DEPTH);
        end else begin
          next_state.write_total = i2c_mss_pkg::PTR_W'(item.write_length);
        end
        next_state.write_position = '0;
        next_state.read_total = item.read_length;
        next_state.read_position = '0;
        next_state.load_pointer = '0;
        next_state.error = i2c_mss_pkg::ERR_NONE;
        next_state.busy = 1'b1;
        result.set_bits = i2c_mss_pkg::BIT_START;
      end
      i2c_mss_pkg::KIND_EVENT: begin
        case (item.bus_status) inside
          i2c_mss_pkg::ST_BUSERR: begin
            next_state.error = i2c_mss_pkg::ERR_BUS;
            next_state.busy = 1'b0;
            result.set_bits = i2c_mss_pkg::BIT_ACK | i2c_mss_pkg::BIT_STOP;
          end
          i2c_mss_pkg::ST_START, i2c_mss_pkg::ST_RSTART: begin
            result.tx_valid = 1'b1;
            result.tx_byte = cur_state.addr_byte;
          end
          i2c_mss_pkg::ST_AW_ACK, i2c_mss_pkg::ST_TX_ACK: begin
            if (item.bus_status == i2c_mss_pkg::ST_AW_ACK) begin
              result.clear_bits = i2c_mss_pkg::BIT_START;
            end
            if (more_write) begin
              result.tx_valid = 1'b1;
              result.tx_byte = buf_data;
              next_state.write_position = cur_state.write_position + 1'b1;
            end else if ((item.bus_status == i2c_mss_pkg::ST_TX_ACK) && (left != 8'd0)) begin
              next_state.addr_byte = cur_state.addr_byte | 8'h01;
              result.set_bits = i2c_mss_pkg::BIT_START;
            end else begin
              next_state.busy = 1'b0;
              result.set_bits = i2c_mss_pkg::BIT_STOP;
            end
          end
          i2c_mss_pkg::ST_AW_NACK, i2c_mss_pkg::ST_AR_NACK: begin
            result.clear_bits = i2c_mss_pkg::BIT_START;
            next_state.error = i2c_mss_pkg::ERR_NO_DEVICE;
            next_state.busy = 1'b0;
            result.set_bits = i2c_mss_pkg::BIT_STOP;
          end
          i2c_mss_pkg::ST_TX_NACK: begin
            next_state.busy = 1'b0;
            result.set_bits = i2c_mss_pkg::BIT_STOP;
          end
          i2c_mss_pkg::ST_ARBLOST: begin
            result.set_bits = i2c_mss_pkg::BIT_START;
          end
          i2c_mss_pkg::ST_AR_ACK: begin
            result.clear_bits = i2c_mss_pkg::BIT_START;
            if (left == 8'd0) begin
              next_state.busy = 1'b0;
              result.set_bits = i2c_mss_pkg::BIT_STOP;
            end else if (left == 8'd1) begin
              result.clear_bits = i2c_mss_pkg::BIT_START | i2c_mss_pkg::BIT_ACK;
            end else begin
              result.set_bits = i2c_mss_pkg::BIT_ACK;
            end
          end
          i2c_mss_pkg::ST_RX_ACK, i2c_mss_pkg::ST_RX_NACK: begin
            if (left != 8'd0) begin
              result.rx_valid = 1'b1;
              result.rx_byte = item.received_byte;
              result.rx_index = cur_state.read_position;
              next_state.read_position = cur_state.read_position + 8'd1;
              left_rx = left - 8'd1;
            end
            if (item.bus_status == i2c_mss_pkg::ST_RX_NACK) begin
              next_state.busy = 1'b0;
              result.set_bits = i2c_mss_pkg::BIT_STOP;
            end else if (left_rx == 8'd1) begin
              result.clear_bits = i2c_mss_pkg::BIT_ACK;
            end else begin
              result.set_bits = i2c_mss_pkg::BIT_ACK;
            end
          end
          i2c_mss_pkg::ST_IDLE: begin
          end
          default: begin
            result.clear_bits = i2c_mss_pkg::BIT_STOP;
          end
        endcase
      end
      default: begin
      end
    endcase

    result.busy_res = next_state.busy;
    result.error_code = next_state.error;
  end

endmodule

// File: hw/rtl/i2c_master_status_sequencer_core.sv
// ----------------------------------------------------------------------------
// I2C master status sequencer core
// A request accepted is held in the input stage; its result is registered on the outputs when that stage advances.
// Throughput: one request per cycle while the output is not stalled, set by the single-pass step logic.
// Reset clears the sequencer state and both pipeline valid flags.
// Write buffer contents are undefined after reset until they are loaded.
// ----------------------------------------------------------------------------
`include "i2c_master_status_sequencer_core_defines.svh"

module i2c_master_status_sequencer_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] kind,
  input  logic [7:0] write_byte,
  input  logic [6:0] target_address,
  input  logic [4:0] write_length,
  input  logic [7:0] read_length,
  input  logic [3:0] bus_status,
  input  logic [7:0] received_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] set_bits,
  output logic [2:0] clear_bits,
  output logic       tx_valid,
  output logic [7:0] tx_byte,
  output logic       rx_valid,
  output logic [7:0] rx_byte,
  output logic [7:0] rx_index,
  output logic       busy_res,
  output logic [1:0] error_code
);

  logic                 s1_valid;
  i2c_mss_pkg::item_t   s1_item;
  i2c_mss_pkg::state_t  state;
  i2c_mss_pkg::state_t  state_next;
  i2c_mss_pkg::result_t res;
  i2c_mss_pkg::result_t res_next;
  logic                 buf_write;
  logic [7:0]           buf_data;
  logic                 advance;

  logic [7:0] write_buffer [i2c_mss_pkg::WRITE_DEPTH];

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;
  assign buf_data = write_buffer[state.write_position[i2c_mss_pkg::IDX_W-1:0]];

  i2c_mss_step u_step (
    .cur_state  (state),
    .item       (s1_item),
    .buf_data   (buf_data),
    .next_state (state_next),
    .result     (res_next),
    .buf_write  (buf_write)
  );

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= '{kind: kind, write_byte: write_byte, target_address: target_address,
                   write_length: write_length, read_length: read_length,
                   bus_status: bus_status, received_byte: received_byte};
    end
    if (advance) begin
      res <= res_next;
    end
    if (advance && buf_write) begin
      write_buffer[state.load_pointer[i2c_mss_pkg::IDX_W-1:0]] <= s1_item.write_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      state     <= '0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
        state     <= state_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign set_bits   = res.set_bits;
  assign clear_bits = res.clear_bits;
  assign tx_valid   = res.tx_valid;
  assign tx_byte    = res.tx_byte;
  assign rx_valid   = res.rx_valid;
  assign rx_byte    = res.rx_byte;
  assign rx_index   = res.rx_index;
  assign busy_res   = res.busy_res;
  assign error_code = res.error_code;

  `I2C_MSS_ASSERT_NEXT(a_start_sets_busy,
    advance && (s1_item.kind == i2c_mss_pkg::KIND_START),
    state.busy && (state.error == i2c_mss_pkg::ERR_NONE) && out_valid && busy_res,
    "Start request did not set busy and clear the error.")
  `I2C_MSS_ASSERT_SAME(a_load_bound, 1'b1,
    state.load_pointer <= i2c_mss_pkg::PTR_W'(i2c_mss_pkg::WRITE_DEPTH),
    "Load pointer ran past the write buffer depth.")
  `I2C_MSS_ASSERT_SAME(a_write_bound, 1'b1,
    state.write_position <= state.write_total,
    "Write position ran past the write total.")
  `I2C_MSS_ASSERT_SAME(a_tx_rx_exclusive, out_valid,
    !(tx_valid && rx_valid),
    "A result carries both a transmit and a received byte.")
  `I2C_MSS_ASSERT_SAME(a_stall_blocks_input, s1_valid && out_valid && !out_ready,
    !in_ready,
    "Input taken while both pipeline stages are full and stalled.")

endmodule
